@@ rtl/srrw_pkg.sv @@
package srrw_pkg;

    // Map geometry: the map is spread over a ring of cells, one column per cell.
    localparam int SEGMENTS   = 1024;
    localparam int MAX_WINDOW = 32;
    localparam int CELLS      = MAX_WINDOW;
    localparam int ROWS       = SEGMENTS / CELLS;
    localparam int CELL_W     = $clog2(CELLS);
    localparam int ROW_W      = $clog2(ROWS);

    // Internal widths
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int NB_W  = $clog2(SEGMENTS + 1);
    localparam int IDX_W = $clog2(SEGMENTS + 2 * MAX_WINDOW + 1);

    // Port field widths
    localparam int SEQ_W      = 10;
    localparam int WS_W       = 6;
    localparam int TS_W       = 11;
    localparam int NEXT_W     = 11;
    localparam int FREE_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS = 1'd1;

    localparam int RESET_WINDOW     = 10;
    localparam int RESET_TOTAL      = 1024;
    localparam int RESET_WINDOW_EFF = (RESET_WINDOW > MAX_WINDOW) ? MAX_WINDOW : RESET_WINDOW;
    localparam int RESET_TOTAL_EFF  = (RESET_TOTAL > SEGMENTS) ? SEGMENTS : RESET_TOTAL;

    // Effective (clamped) configuration seen by every cell
    typedef struct packed {
        logic [WIN_W-1:0] win;
        logic [NB_W-1:0]  total;
    } cfg_t;

    // Write request into one column of the map
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic             value;
    } wr_t;

    // Scan token travelling around the ring
    typedef struct packed {
        logic             valid;
        logic             done;
        logic             adv;
        logic [IDX_W-1:0] idx;
        logic [NB_W-1:0]  nbase;
        logic [WIN_W-1:0] n;
        logic [WIN_W-1:0] used;
    } tok_t;

endpackage

@@ rtl/selective_repeat_receive_window.sv @@
// Selective-repeat receive window.
// Input channel (in_valid/in_ready) carries one arriving segment: seq_num and
// checksum_ok. A segment with a bad checksum is taken without a scan and gives no
// result. A good one sets its bit in the received map and yields one request on
// the output channel (out_valid/out_ready): ack_num, next_expected, free_slots.
// The map is spread over a ring of 32 cells, one column each. A scan token walks
// the ring one cell per cycle: first past the in-order run (base advance), then
// over one window counting received slots; total_segments can end the scan early.
// No new segment is taken while a scan is in work, so a good segment holds the
// input until its scan is done; the token's walk through the ring sets the rate.
// After reset the map is cleared one row per cycle, all 32 rows, with in_ready low.
// Configuration writes are taken at any time, including during the clear.
// When the receiver stalls, one result waits in the output register and one more
// in a hold stage; input ready stays low while the hold stage is occupied.
module selective_repeat_receive_window (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [srrw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srrw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [srrw_pkg::SEQ_W-1:0]        seq_num,
    input  logic                              checksum_ok,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [srrw_pkg::SEQ_W-1:0]        ack_num,
    output logic [srrw_pkg::NEXT_W-1:0]       next_expected,
    output logic [srrw_pkg::FREE_W-1:0]       free_slots
);

    typedef struct packed {
        logic [srrw_pkg::SEQ_W-1:0]  ack;
        logic [srrw_pkg::NEXT_W-1:0] next;
        logic [srrw_pkg::FREE_W-1:0] free;
    } res_t;

    srrw_pkg::cfg_t             cfg_reg;
    logic                       clr_active_reg;
    logic [srrw_pkg::ROW_W-1:0] clr_row_reg;
    logic [srrw_pkg::NB_W-1:0]  base_reg;
    logic                       busy_reg;
    logic                       launch_reg;
    srrw_pkg::tok_t             launch_tok_reg;
    logic [srrw_pkg::SEQ_W-1:0] seq_reg;
    logic                       out_valid_reg;
    res_t                       out_res_reg;
    logic                       hold_valid_reg;
    res_t                       hold_res_reg;

    logic                       accept;
    logic                       good;
    logic [srrw_pkg::IDX_W-1:0] seq_ext;
    logic                       store;
    logic [srrw_pkg::WS_W-1:0]  ws_data;
    logic [srrw_pkg::TS_W-1:0]  ts_data;
    logic [srrw_pkg::WIN_W-1:0] ws_clamp;
    logic [srrw_pkg::NB_W-1:0]  ts_clamp;
    srrw_pkg::tok_t             tok_q [srrw_pkg::CELLS];
    srrw_pkg::wr_t              wr_q [srrw_pkg::CELLS];
    logic [srrw_pkg::CELLS-1:0] launch_q;
    logic [srrw_pkg::CELLS-1:0] tok_valid_vec;
    srrw_pkg::tok_t             done_tok;
    logic                       done_any;
    res_t                       result;
    logic                       out_free;

    assign in_ready = !clr_active_reg && !busy_reg && !hold_valid_reg;
    assign accept   = in_valid && in_ready;
    assign good     = accept && checksum_ok;
    assign seq_ext  = srrw_pkg::IDX_W'(seq_num);
    assign store    = seq_ext < srrw_pkg::IDX_W'(srrw_pkg::SEGMENTS);

    // Clamp register values on write so the cells see effective values only.
    assign ws_data  = cfg_data[srrw_pkg::WS_W-1:0];
    assign ts_data  = cfg_data[srrw_pkg::TS_W-1:0];

    always_comb
    begin
        if (ws_data == '0)
        begin
            ws_clamp = srrw_pkg::WIN_W'(1);
        end
        else if (int'(ws_data) > srrw_pkg::MAX_WINDOW)
        begin
            ws_clamp = srrw_pkg::WIN_W'(srrw_pkg::MAX_WINDOW);
        end
        else
        begin
            ws_clamp = srrw_pkg::WIN_W'(ws_data);
        end

        if (ts_data == '0)
        begin
            ts_clamp = srrw_pkg::NB_W'(1);
        end
        else if (int'(ts_data) > srrw_pkg::SEGMENTS)
        begin
            ts_clamp = srrw_pkg::NB_W'(srrw_pkg::SEGMENTS);
        end
        else
        begin
            ts_clamp = srrw_pkg::NB_W'(ts_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win   <= srrw_pkg::WIN_W'(srrw_pkg::RESET_WINDOW_EFF);
            cfg_reg.total <= srrw_pkg::NB_W'(srrw_pkg::RESET_TOTAL_EFF);
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == srrw_pkg::CFG_WINDOW_SIZE)
            begin
                cfg_reg.win <= ws_clamp;
            end
            else if (cfg_index == srrw_pkg::CFG_TOTAL_SEGMENTS)
            begin
                cfg_reg.total <= ts_clamp;
            end
        end
    end

    // Map writes: the clear pass hits one row in every column at once.
    always_comb
    begin
        for (int i = 0; i < srrw_pkg::CELLS; i++)
        begin
            wr_q[i].en    = clr_active_reg ||
                            (good && store &&
                             (seq_ext[srrw_pkg::CELL_W-1:0] == srrw_pkg::CELL_W'(i)));
            wr_q[i].row   = clr_active_reg ? clr_row_reg
                                           : seq_ext[srrw_pkg::CELL_W +: srrw_pkg::ROW_W];
            wr_q[i].value = !clr_active_reg;
            launch_q[i]   = launch_reg &&
                            (launch_tok_reg.idx[srrw_pkg::CELL_W-1:0] ==
                             srrw_pkg::CELL_W'(i));
        end
    end

    for (genvar g = 0; g < srrw_pkg::CELLS; g++)
    begin : g_cell
        srrw_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cfg          (cfg_reg),
            .wr           (wr_q[g]),
            .launch       (launch_q[g]),
            .launch_token (launch_tok_reg),
            .prev_token   (tok_q[(g + srrw_pkg::CELLS - 1) % srrw_pkg::CELLS]),
            .token        (tok_q[g])
        );
    end

    // Pick up the finished token from whichever cell holds it.
    always_comb
    begin
        done_tok = '0;
        for (int i = 0; i < srrw_pkg::CELLS; i++)
        begin
            tok_valid_vec[i] = tok_q[i].valid;
            if (tok_q[i].valid && tok_q[i].done)
            begin
                done_tok = done_tok | tok_q[i];
            end
        end
        done_any    = done_tok.valid;
        result.ack  = seq_reg;
        result.next = srrw_pkg::NEXT_W'(done_tok.nbase);
        result.free = srrw_pkg::FREE_W'(cfg_reg.win - done_tok.used);
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            base_reg       <= '0;
            busy_reg       <= 1'b0;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_row_reg <= clr_row_reg + srrw_pkg::ROW_W'(1);
                if (clr_row_reg == srrw_pkg::ROW_W'(srrw_pkg::ROWS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end

            launch_reg <= good;
            if (good)
            begin
                busy_reg <= 1'b1;
            end
            else if (done_any)
            begin
                busy_reg <= 1'b0;
                base_reg <= done_tok.nbase;
            end

            if (out_free)
            begin
                if (hold_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    hold_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= done_any;
                end
            end
            else if (done_any)
            begin
                hold_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (good)
        begin
            seq_reg              <= seq_num;
            launch_tok_reg.valid <= 1'b1;
            launch_tok_reg.done  <= 1'b0;
            launch_tok_reg.adv   <= seq_ext == srrw_pkg::IDX_W'(base_reg);
            launch_tok_reg.idx   <= srrw_pkg::IDX_W'(base_reg);
            launch_tok_reg.nbase <= base_reg;
            launch_tok_reg.n     <= '0;
            launch_tok_reg.used  <= '0;
        end
        if (out_free)
        begin
            out_res_reg <= hold_valid_reg ? hold_res_reg : result;
        end
        else if (done_any)
        begin
            hold_res_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign ack_num       = out_res_reg.ack;
    assign next_expected = out_res_reg.next;
    assign free_slots    = out_res_reg.free;

    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one scan token in the ring");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_any |-> busy_reg)
        else $error("scan finished with no segment in work");

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold stage full while output register empty");

    a_base_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        done_any |=> (base_reg >= $past(base_reg)))
        else $error("window base moved backward");

endmodule

@@ rtl/srrw_cell.sv @@
module srrw_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  srrw_pkg::cfg_t                  cfg,
    input  srrw_pkg::wr_t                   wr,
    input  logic                            launch,
    input  srrw_pkg::tok_t                  launch_token,
    input  srrw_pkg::tok_t                  prev_token,
    output srrw_pkg::tok_t                  token
);

    logic           map_reg [srrw_pkg::ROWS];
    srrw_pkg::tok_t tok_reg;
    srrw_pkg::tok_t tok_next;
    srrw_pkg::tok_t cur;
    logic           bit_v;
    logic           in_rng;
    logic [srrw_pkg::WIN_W-1:0] cnt;
    logic [srrw_pkg::NB_W-1:0]  nb;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            map_reg[wr.row] <= wr.value;
        end
    end

    always_comb
    begin
        cur      = launch ? launch_token : prev_token;
        bit_v    = map_reg[cur.idx[srrw_pkg::CELL_W +: srrw_pkg::ROW_W]];
        in_rng   = cur.idx < srrw_pkg::IDX_W'(cfg.total);
        cnt      = cur.adv ? '0 : cur.n;
        nb       = cur.adv ? srrw_pkg::NB_W'(cur.idx) : cur.nbase;
        tok_next = cur;
        if (!cur.valid || cur.done)
        begin
            // drop a finished token once it has been seen
            tok_next = '0;
        end
        else if (cur.adv && (cur.n < cfg.win) && in_rng && bit_v)
        begin
            tok_next.n   = cur.n + srrw_pkg::WIN_W'(1);
            tok_next.idx = cur.idx + srrw_pkg::IDX_W'(1);
        end
        else if ((cnt < cfg.win) && in_rng)
        begin
            tok_next.adv   = 1'b0;
            tok_next.nbase = nb;
            tok_next.n     = cnt + srrw_pkg::WIN_W'(1);
            tok_next.used  = cur.used + srrw_pkg::WIN_W'(bit_v);
            tok_next.idx   = cur.idx + srrw_pkg::IDX_W'(1);
        end
        else
        begin
            tok_next.adv   = 1'b0;
            tok_next.nbase = nb;
            tok_next.n     = cnt;
            tok_next.done  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign token = tok_reg;

endmodule

@@ tb/sv/tb.sv @@
module tb;

    localparam int LIMIT    = 1_000_000;
    localparam int SETTLE   = 2 * srrw_pkg::MAX_WINDOW + 40;
    localparam int HOLD_OFF = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    class ack_scoreboard;
        typedef struct packed {
            logic [srrw_pkg::SEQ_W-1:0]  ack;
            logic [srrw_pkg::NEXT_W-1:0] next_exp;
            logic [srrw_pkg::FREE_W-1:0] free;
        } ack_t;

        bit                        received [srrw_pkg::SEGMENTS];
        int                        base;
        logic [srrw_pkg::WS_W-1:0] win_reg;
        logic [srrw_pkg::TS_W-1:0] total_reg;
        ack_t                      acks_due [$];
        int                        errors;

        function new();
            foreach (received[i]) received[i] = 1'b0;
            base      = 0;
            win_reg   = srrw_pkg::WS_W'(srrw_pkg::RESET_WINDOW);
            total_reg = srrw_pkg::TS_W'(srrw_pkg::RESET_TOTAL);
            errors    = 0;
        endfunction

        function int window_len();
            if (win_reg < 1) return 1;
            if (win_reg > srrw_pkg::MAX_WINDOW) return srrw_pkg::MAX_WINDOW;
            return int'(win_reg);
        endfunction

        function int total_len();
            if (total_reg < 1) return 1;
            if (total_reg > srrw_pkg::SEGMENTS) return srrw_pkg::SEGMENTS;
            return int'(total_reg);
        endfunction

        function void write_reg(logic [srrw_pkg::CFG_IDX_W-1:0] idx,
                                logic [srrw_pkg::CFG_DATA_W-1:0] data);
            if (idx == srrw_pkg::CFG_WINDOW_SIZE)
                win_reg = data[srrw_pkg::WS_W-1:0];
            else if (idx == srrw_pkg::CFG_TOTAL_SEGMENTS)
                total_reg = data[srrw_pkg::TS_W-1:0];
        endfunction

        function void note_segment(logic [srrw_pkg::SEQ_W-1:0] seq, logic ok);
            int   w;
            int   t;
            int   used;
            ack_t a;
            w    = window_len();
            t    = total_len();
            used = 0;
            if (!ok)
                return;
            received[seq] = 1'b1;
            // advance past the in-order run, capped by window and transfer size
            if (int'(seq) == base)
            begin
                for (int i = 0; i < w; i++)
                begin
                    if (base >= t || base >= srrw_pkg::SEGMENTS || !received[base])
                        break;
                    base++;
                end
            end
            for (int i = 0; i < w; i++)
            begin
                if (base + i >= t)
                    break;
                if (base + i < srrw_pkg::SEGMENTS && received[base + i])
                    used++;
            end
            a.ack      = seq;
            a.next_exp = base[srrw_pkg::NEXT_W-1:0];
            a.free     = srrw_pkg::FREE_W'(w - used);
            acks_due.push_back(a);
        endfunction

        function void check_ack(logic [srrw_pkg::SEQ_W-1:0] ack,
                                logic [srrw_pkg::NEXT_W-1:0] next_exp,
                                logic [srrw_pkg::FREE_W-1:0] free);
            ack_t e;
            if (acks_due.size() == 0)
            begin
                $display("%0t: ack expected none, actual %0d next %0d free %0d",
                         $time, ack, next_exp, free);
                errors++;
                return;
            end
            e = acks_due.pop_front();
            if (ack !== e.ack)
            begin
                $display("%0t: ack_num expected %0d actual %0d", $time, e.ack, ack);
                errors++;
            end
            if (next_exp !== e.next_exp)
            begin
                $display("%0t: next_expected expected %0d actual %0d", $time, e.next_exp,
                         next_exp);
                errors++;
            end
            if (free !== e.free)
            begin
                $display("%0t: free_slots expected %0d actual %0d", $time, e.free, free);
                errors++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [srrw_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [srrw_pkg::SEQ_W-1:0]      seq_num;
    logic                            checksum_ok;
    logic                            out_valid;
    logic                            out_ready;
    logic [srrw_pkg::SEQ_W-1:0]      ack_num;
    logic [srrw_pkg::NEXT_W-1:0]     next_expected;
    logic [srrw_pkg::FREE_W-1:0]     free_slots;

    ack_scoreboard sb = new();
    idle_mode_t    idle_mode = IDLE_NONE;
    int            hold_req = 0;
    int            cycle_count = 0;

    selective_repeat_receive_window i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .seq_num       (seq_num),
        .checksum_ok   (checksum_ok),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ack_num       (ack_num),
        .next_expected (next_expected),
        .free_slots    (free_slots)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // ack side: check, then pick next cycle's ready
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_ack(ack_num, next_expected, free_slots);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (idle_mode == IDLE_RECEIVER)
                out_ready <= ($urandom_range(0, 99) >= 47);
            else if (idle_mode == IDLE_BOTH)
                out_ready <= ($urandom_range(0, 99) >= 18);
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_segment(input logic [srrw_pkg::SEQ_W-1:0] seq, input logic ok);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 47 : (idle_mode == IDLE_BOTH) ? 18 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        seq_num     <= seq;
        checksum_ok <= ok;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_segment(seq, ok);
    endtask

    task automatic write_regs(input logic [srrw_pkg::CFG_DATA_W-1:0] win_data,
                              input logic [srrw_pkg::CFG_DATA_W-1:0] total_data);
        cfg_wr_en <= 1'b1;
        cfg_index <= srrw_pkg::CFG_WINDOW_SIZE;
        cfg_data  <= win_data;
        @(posedge clk);
        sb.write_reg(srrw_pkg::CFG_WINDOW_SIZE, win_data);
        cfg_index <= srrw_pkg::CFG_TOTAL_SEGMENTS;
        cfg_data  <= total_data;
        @(posedge clk);
        sb.write_reg(srrw_pkg::CFG_TOTAL_SEGMENTS, total_data);
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid, wait for every ack, then let a dropped segment finish
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.acks_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_directed();
        logic [srrw_pkg::SEQ_W-1:0] seqs [16] = '{10'd0, 10'd0, 10'd2, 10'd1, 10'd1023,
                                                  10'd1023, 10'd12, 10'd3, 10'd4, 10'h155,
                                                  10'h2AA, 10'd5, 10'd7, 10'd6, 10'd12,
                                                  10'd13};
        logic                       oks  [16] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                                  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                                                  1'b1, 1'b0};
        idle_mode = IDLE_NONE;
        for (int i = 0; i < 16; i++)
            send_segment(seqs[i], oks[i]);
        settle();
    endtask

    // mostly segments in and just past the window, so the base keeps moving
    task automatic run_random(input int num_items, input idle_mode_t mode);
        int                         sent;
        int                         cur_base;
        int                         w;
        int                         roll;
        logic [srrw_pkg::SEQ_W-1:0] seq;
        logic                       ok;
        idle_mode = mode;
        sent = 0;
        while (sent < num_items)
        begin
            cur_base = sb.base;
            w        = sb.window_len();
            roll     = $urandom_range(0, 99);
            ok       = 1'b1;
            if (roll < 8)
            begin
                seq = srrw_pkg::SEQ_W'($urandom);
                ok  = 1'b0;
            end
            else if (roll < 22)
                seq = srrw_pkg::SEQ_W'(cur_base);
            else if (roll < 76)
                seq = srrw_pkg::SEQ_W'(cur_base + $urandom_range(0, w + 1));
            else if (roll < 88)
                seq = srrw_pkg::SEQ_W'(cur_base - $urandom_range(1, 8));
            else
            begin
                seq = srrw_pkg::SEQ_W'($urandom);
                ok  = 1'($urandom);
            end
            send_segment(seq, ok);
            sent++;
        end
        settle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = srrw_pkg::CFG_WINDOW_SIZE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        seq_num     = '0;
        checksum_ok = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();

        // zero window and zero total both clamp to one; base now sits above the total
        write_regs(11'h7C0, 11'd0);
        run_random(12, IDLE_NONE);

        // oversized values clamp to the maximum
        write_regs(11'h7FF, 11'h7FF);
        run_random(250, IDLE_SENDER);

        // scan capped by the transfer size; hold acks off so the input backs up
        write_regs(11'd1, srrw_pkg::CFG_DATA_W'(sb.base + 20));
        hold_req = HOLD_OFF;
        run_random(150, IDLE_RECEIVER);

        write_regs(11'd32, 11'd1024);
        run_random(300, IDLE_BOTH);

        write_regs(srrw_pkg::CFG_DATA_W'($urandom_range(2, 31)),
                   srrw_pkg::CFG_DATA_W'($urandom_range(1024, 2047)));
        run_random(300, IDLE_NONE);

        write_regs(11'd10, srrw_pkg::CFG_DATA_W'(sb.base + 5));
        run_random(100, IDLE_SENDER);

        write_regs(11'd32, 11'd1024);
        hold_req = HOLD_OFF;
        run_random(400, IDLE_RECEIVER);

        write_regs(srrw_pkg::CFG_DATA_W'($urandom_range(1, 32)), 11'd1024);
        run_random(450, IDLE_BOTH);

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
